/* hdl/brb_pkg.sv */
// Shared types and codes for the broadcast ring buffer.
`timescale 1ns / 1ps
`default_nettype none

package brb_pkg;

    localparam int DATA_W   = 32;
    localparam int READER_W = 3;
    localparam int STATUS_W = 2;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic                opcode;
        logic [READER_W-1:0] reader;
        logic [DATA_W-1:0]   data_in;
    } t_in_word;

    typedef struct packed {
        logic                accepted;
        logic [DATA_W-1:0]   data_out;
        logic [STATUS_W-1:0] status;
        logic                slot_freed;
    } t_out_word;

endpackage

`default_nettype wire

/* hdl/broadcast_ring_buffer_core.sv */
// Top level of the broadcast ring buffer: slot ring, reader pointers and result register.
`timescale 1ns / 1ps
`default_nettype none

// One write or read word is taken per cycle while the input is not stalled; its result
// word appears in the output register in the cycle after; the output register is loaded
// in the same cycle that the slot memory's registered read port delivers the stored word.
// The input is stalled only while a result sits in the output register and the
// output side stalls. Each write broadcasts its word to all READERS readers; a
// slot returns to the free pool once every reader has read it. Writes to a full
// ring and reads with nothing pending are rejected with a status code.
module broadcast_ring_buffer_core #(
    parameter int SLOTS   = 4,
    parameter int READERS = 8
) (
    input  wire                logic i_clk,
    input  wire                logic i_rst_n,
    input  wire                logic i_in_valid,
    output                     logic o_in_stall,
    input  wire brb_pkg::t_in_word   i_in_word,
    output                     logic o_out_valid,
    input  wire                logic i_out_stall,
    output brb_pkg::t_out_word o_out_word
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int RW = (READERS > 1) ? $clog2(READERS) : 1;
    localparam int PW = $clog2(SLOTS + 1);
    localparam int CW = (READERS > 1) ? $clog2(READERS) : 1;

    function automatic logic [SW-1:0] f_next_slot(input logic [SW-1:0] s);
        return (s == SW'(SLOTS - 1)) ? '0 : s + SW'(1);
    endfunction

    logic [brb_pkg::DATA_W-1:0] r_mem [SLOTS];

    logic [SW-1:0] r_wslot, n_wslot;
    logic [PW-1:0] r_free,  n_free;
    logic [CW-1:0] r_cnt   [SLOTS];
    logic [CW-1:0] n_cnt   [SLOTS];
    logic [SW-1:0] r_rslot [READERS];
    logic [SW-1:0] n_rslot [READERS];
    logic [PW-1:0] r_pend  [READERS];
    logic [PW-1:0] n_pend  [READERS];

    logic                         r_out_valid;
    logic                         r_acc,    n_acc;
    logic [brb_pkg::STATUS_W-1:0] r_status, n_status;
    logic                         r_freed,  n_freed;
    logic                         r_rd_hit;
    logic [brb_pkg::DATA_W-1:0]   r_rd_data;

    logic          in_acc;
    logic          wr_en;
    logic          rd_in;
    logic [RW-1:0] idx;
    logic [SW-1:0] rs;
    logic [PW-1:0] pend_sel;

    assign o_in_stall = r_out_valid & i_out_stall;
    assign in_acc     = i_in_valid & ~o_in_stall;

    assign rd_in    = (int'(i_in_word.reader) < READERS);
    assign idx      = RW'(i_in_word.reader);
    assign rs       = rd_in ? r_rslot[idx] : '0;
    assign pend_sel = rd_in ? r_pend[idx] : '0;

    always_comb begin
        n_wslot  = r_wslot;
        n_free   = r_free;
        n_cnt    = r_cnt;
        n_rslot  = r_rslot;
        n_pend   = r_pend;
        n_acc    = 1'b0;
        n_status = brb_pkg::ST_OK;
        n_freed  = 1'b0;
        wr_en    = 1'b0;
        if (in_acc) begin
            if (i_in_word.opcode == brb_pkg::OP_WRITE) begin
                if (r_free == '0) begin
                    n_status = brb_pkg::ST_FULL;
                end else begin
                    wr_en   = 1'b1;
                    n_wslot = f_next_slot(r_wslot);
                    n_free  = r_free - PW'(1);
                    for (int i = 0; i < READERS; i++) begin
                        n_pend[i] = r_pend[i] + PW'(1);
                    end
                    n_acc = 1'b1;
                end
            end else begin
                if (!rd_in || pend_sel == '0) begin
                    n_status = brb_pkg::ST_EMPTY;
                end else begin
                    n_pend[idx]  = pend_sel - PW'(1);
                    n_rslot[idx] = f_next_slot(rs);
                    if (r_cnt[rs] == CW'(READERS - 1)) begin
                        // last reader of this slot: hand it back to the writer
                        n_cnt[rs] = '0;
                        if (r_free < PW'(SLOTS)) begin
                            n_free = r_free + PW'(1);
                        end
                        n_freed = 1'b1;
                    end else begin
                        n_cnt[rs] = r_cnt[rs] + CW'(1);
                    end
                    n_acc = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wslot     <= '0;
            r_free      <= PW'(SLOTS);
            r_out_valid <= 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                r_cnt[i] <= '0;
            end
            for (int i = 0; i < READERS; i++) begin
                r_rslot[i] <= '0;
                r_pend[i]  <= '0;
            end
        end else begin
            r_wslot <= n_wslot;
            r_free  <= n_free;
            r_cnt   <= n_cnt;
            r_rslot <= n_rslot;
            r_pend  <= n_pend;
            if (in_acc) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wslot] <= i_in_word.data_in;
        end
        if (in_acc) begin
            r_rd_data <= r_mem[rs];
            r_acc     <= n_acc;
            r_status  <= n_status;
            r_freed   <= n_freed;
            r_rd_hit  <= n_acc & (i_in_word.opcode == brb_pkg::OP_READ);
        end
    end

    assign o_out_valid = r_out_valid;

    always_comb begin
        o_out_word.accepted   = r_acc;
        o_out_word.data_out   = r_rd_hit ? r_rd_data : '0;
        o_out_word.status     = r_status;
        o_out_word.slot_freed = r_freed;
    end

endmodule

`default_nettype wire

/* hdl/brb_checker.sv */
// Port-level assertions for the broadcast ring buffer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module brb_checker (
    input wire                logic i_clk,
    input wire                logic i_rst_n,
    input wire                logic i_in_valid,
    input wire                logic o_in_stall,
    input wire brb_pkg::t_in_word   i_in_word,
    input wire                logic o_out_valid,
    input wire                logic i_out_stall,
    input wire brb_pkg::t_out_word  o_out_word
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_out_valid)
        else $error("accepted word produced no result");

    a_status_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.accepted == (o_out_word.status == brb_pkg::ST_OK)))
        else $error("accepted flag disagrees with status");

    a_reject_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_word.accepted) |->
            (o_out_word.data_out == '0 && !o_out_word.slot_freed))
        else $error("rejected word carries data or freed a slot");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_word)))
        else $error("stalled result changed");

endmodule

bind broadcast_ring_buffer_core brb_checker u_brb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_word   (i_in_word),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);

`default_nettype wire

/* bench/tb.sv */
// Testbench for broadcast_ring_buffer_core: random and directed words checked against a predictor.
`timescale 1ns / 1ps

module tb;

    localparam int SLOTS        = 4;
    localparam int READERS      = 8;
    localparam int SLOT_W       = $clog2(SLOTS);
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 8;
    localparam int LIMIT_NS     = 2000000;
    localparam int PHASE_ITEMS  = 125;

    class ring_scoreboard;
        bit [SLOT_W-1:0]          wr_slot;
        bit [2:0]                 free_cnt;
        bit [brb_pkg::DATA_W-1:0] slot_data [SLOTS];
        bit [3:0]                 read_cnt [SLOTS];
        bit [SLOT_W-1:0]          rd_slot [READERS];
        bit [2:0]                 rd_pending [READERS];
        brb_pkg::t_out_word       expected_q [$];
        int                       fails;

        function new();
            wr_slot  = '0;
            free_cnt = 3'(SLOTS);
            fails    = 0;
            foreach (read_cnt[i]) begin
                read_cnt[i]  = '0;
                slot_data[i] = '0;
            end
            foreach (rd_slot[i]) begin
                rd_slot[i]    = '0;
                rd_pending[i] = '0;
            end
        endfunction

        function bit [SLOT_W-1:0] ring_next(bit [SLOT_W-1:0] s);
            return (int'(s) == SLOTS - 1) ? '0 : s + 1'b1;
        endfunction

        function bit has_pending(int r);
            return rd_pending[r] != 0;
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction

        // Predict the result of one accepted input word.
        function void note_input(brb_pkg::t_in_word w);
            brb_pkg::t_out_word res;
            bit [SLOT_W-1:0]    s;
            int                 r;
            res        = '0;
            res.status = brb_pkg::ST_OK;
            r          = int'(w.reader);
            if (w.opcode == brb_pkg::OP_WRITE) begin
                if (free_cnt == 0) begin
                    res.status = brb_pkg::ST_FULL;
                end else begin
                    s            = wr_slot;
                    slot_data[s] = w.data_in;
                    wr_slot      = ring_next(s);
                    free_cnt     = free_cnt - 1'b1;
                    foreach (rd_pending[i]) rd_pending[i] = rd_pending[i] + 1'b1;
                    res.accepted = 1'b1;
                end
            end else if (r >= READERS || rd_pending[r] == 0) begin
                res.status = brb_pkg::ST_EMPTY;
            end else begin
                s             = rd_slot[r];
                res.data_out  = slot_data[s];
                rd_pending[r] = rd_pending[r] - 1'b1;
                rd_slot[r]    = ring_next(s);
                read_cnt[s]   = read_cnt[s] + 1'b1;
                if (int'(read_cnt[s]) >= READERS) begin
                    read_cnt[s] = '0;
                    if (int'(free_cnt) < SLOTS) free_cnt = free_cnt + 1'b1;
                    res.slot_freed = 1'b1;
                end
                res.accepted = 1'b1;
            end
            expected_q.push_back(res);
        endfunction

        function void check_result(brb_pkg::t_out_word got);
            brb_pkg::t_out_word want;
            if (expected_q.size() == 0) begin
                $error("result word with nothing expected: %h", got);
                fails++;
                return;
            end
            want = expected_q.pop_front();
            if (got.accepted !== want.accepted) begin
                $error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
                fails++;
            end
            if (got.data_out !== want.data_out) begin
                $error("data_out: expected %h, got %h", want.data_out, got.data_out);
                fails++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                fails++;
            end
            if (got.slot_freed !== want.slot_freed) begin
                $error("slot_freed: expected %0d, got %0d", want.slot_freed, got.slot_freed);
                fails++;
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    brb_pkg::t_in_word  i_in_word;
    logic               o_out_valid;
    logic               i_out_stall;
    brb_pkg::t_out_word o_out_word;

    ring_scoreboard sb;
    bit             idle_on  = 1'b0;
    bit             hold_req = 1'b0;

    broadcast_ring_buffer_core #(
        .SLOTS   (SLOTS),
        .READERS (READERS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    always #2 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic brb_pkg::t_in_word mk_word(logic op, int r,
                                                  logic [brb_pkg::DATA_W-1:0] d);
        brb_pkg::t_in_word w;
        w.opcode  = op;
        w.reader  = brb_pkg::READER_W'(r);
        w.data_in = d;
        return w;
    endfunction

    // Returns at the edge where the word was taken.
    task automatic send_word(brb_pkg::t_in_word w);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic run_phase(int n, int write_pct);
        brb_pkg::t_in_word w;
        int                tries;
        for (int k = 0; k < n; k++) begin
            w.opcode  = ($urandom_range(0, 99) < write_pct) ? brb_pkg::OP_WRITE
                                                             : brb_pkg::OP_READ;
            w.reader  = brb_pkg::READER_W'($urandom_range(0, READERS - 1));
            w.data_in = $urandom();
            case ($urandom_range(0, 15))
                0: w.data_in = '0;
                1: w.data_in = '1;
                default: ;
            endcase
            // mostly pick a reader that has something pending
            if (w.opcode == brb_pkg::OP_READ && $urandom_range(0, 3) != 0) begin
                tries = 0;
                while (!sb.has_pending(int'(w.reader)) && tries < 8) begin
                    w.reader = brb_pkg::READER_W'($urandom_range(0, READERS - 1));
                    tries++;
                end
            end
            send_word(w);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) sb.check_result(o_out_word);
            if (i_in_valid && !o_in_stall) sb.note_input(i_in_word);
        end
    end

    initial begin
        i_out_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                int n;
                n = pick_gap();
                if (n > 0) begin
                    i_out_stall <= 1'b1;
                    repeat (n) @(posedge i_clk);
                end
            end
            i_out_stall <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    initial begin
        #(LIMIT_NS);
        $display("tb: errors");
        $finish;
    end

    initial begin
        int write_pct [10];
        write_pct = '{12, 50, 8, 25, 11, 90, 5, 15, 11, 30};
        sb = new();
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_word  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty reads, fill to full, full rejection
        send_word(mk_word(brb_pkg::OP_READ, 0, '0));
        send_word(mk_word(brb_pkg::OP_READ, READERS - 1, '1));
        send_word(mk_word(brb_pkg::OP_WRITE, 5, 32'h0000_0000));
        send_word(mk_word(brb_pkg::OP_WRITE, 2, 32'hFFFF_FFFF));
        send_word(mk_word(brb_pkg::OP_WRITE, 0, 32'hA5A5_A5A5));
        send_word(mk_word(brb_pkg::OP_WRITE, 7, 32'h5A5A_5A5A));
        send_word(mk_word(brb_pkg::OP_WRITE, 1, 32'h1234_5678));
        // every reader takes the first slot; the last read frees it
        for (int r = 0; r < READERS; r++) begin
            send_word(mk_word(brb_pkg::OP_READ, r, 32'hFFFF_FFFF));
        end
        // write wraps to slot zero
        send_word(mk_word(brb_pkg::OP_WRITE, 3, 32'hDEAD_BEEF));
        // one reader drains its queue and then reads empty
        for (int k = 0; k < SLOTS + 1; k++) send_word(mk_word(brb_pkg::OP_READ, 3, '0));

        for (int p = 0; p < 10; p++) begin
            idle_on = (p == 0 || p == 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
            if (p == 1) hold_req = 1'b1;
            run_phase(PHASE_ITEMS, write_pct[p]);
        end
        i_in_valid <= 1'b0;

        @(posedge i_clk);
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.fails == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
